FILE: rtl/core/w2v_pkg.sv
// shared types, widths and constants for the world-to-vehicle frame transform
// depends on nothing; every other file of the block imports it
package w2v_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int GUARD_BITS   = 8;
  localparam int CORDIC_STEPS = 24;
  localparam int HEAD_W       = 16;

  // rotation datapath: difference, guard bits and cordic growth
  localparam int XW      = COORD_WIDTH + GUARD_BITS + 3;
  localparam int ZW      = 34;
  localparam int SHIFT_W = $clog2(CORDIC_STEPS);
  localparam int ANG_W   = HEAD_W + 1;
  localparam int ZFRAC   = 16;

  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(16384);

  // gain correction: magnitude split into chunks for narrow multipliers
  localparam int                GAIN_W     = 30;
  localparam logic [GAIN_W-1:0] GAIN_K     = GAIN_W'(652032874);
  localparam int                GAIN_SHIFT = 30 + GUARD_BITS;
  localparam int                CHUNK_W    = 21;
  localparam int                NCHUNK     = (XW + CHUNK_W - 1) / CHUNK_W;
  localparam int                MAGP_W     = NCHUNK * CHUNK_W;
  localparam int                PROD_W     = CHUNK_W + GAIN_W;
  localparam int                FULL_W     = MAGP_W + GAIN_W + 1;
  localparam int                R_W        = FULL_W - GAIN_SHIFT;

  localparam logic signed [COORD_WIDTH-1:0] OUT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] OUT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // prerotation register, cordic cells and gain stages
  localparam int LATENCY = CORDIC_STEPS + 5;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    ZW'(536870912), ZW'(316933406), ZW'(167458907), ZW'(85004756),
    ZW'(42667331),  ZW'(21354465),  ZW'(10679838),  ZW'(5340245),
    ZW'(2670163),   ZW'(1335087),   ZW'(667544),    ZW'(333772),
    ZW'(166886),    ZW'(83443),     ZW'(41722),     ZW'(20861),
    ZW'(10430),     ZW'(5215),      ZW'(2608),      ZW'(1304),
    ZW'(652),       ZW'(326),       ZW'(163),       ZW'(81)
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [HEAD_W-1:0]             heading_t;

  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

FILE: rtl/core/world_to_vehicle_frame_transform.sv
// top level: waypoint into the vehicle frame through a pipelined cordic row
// depends on w2v_pkg, w2v_prerot, w2v_cordic_cell, w2v_gain
//
//   channel   direction  handshake          payload
//   request   in         start_i / busy_o   vehicle_x_i vehicle_y_i heading_i point_x_i point_y_i
//   result    out        valid_o strobe     local_x_o local_y_o saturated_o
//
// one request per cycle, every cycle; busy_o stays low
// a result comes out through one fold stage,
// 24 cordic cells and four gain stages, one register each
// reset clears only the valid bits of the pipeline
// results are shown for one cycle; the receiver cannot stall them
module world_to_vehicle_frame_transform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  w2v_pkg::coord_t   vehicle_x_i,
  input  w2v_pkg::coord_t   vehicle_y_i,
  input  w2v_pkg::heading_t heading_i,
  input  w2v_pkg::coord_t   point_x_i,
  input  w2v_pkg::coord_t   point_y_i,
  output logic              valid_o,
  output w2v_pkg::coord_t   local_x_o,
  output w2v_pkg::coord_t   local_y_o,
  output logic              saturated_o
);
  import w2v_pkg::*;

  cordic_t chain [CORDIC_STEPS+1];

  assign busy_o = 1'b0;

  w2v_prerot u_prerot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (start_i && !busy_o),
    .vehicle_x_i (vehicle_x_i),
    .vehicle_y_i (vehicle_y_i),
    .heading_i   (heading_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_o       (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    w2v_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SHIFT_W'(i)),
      .atan_i  (ATAN_TURNS[i]),
      .in_i    (chain[i]),
      .out_o   (chain[i+1])
    );
  end

  w2v_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (chain[CORDIC_STEPS]),
    .valid_o     (valid_o),
    .local_x_o   (local_x_o),
    .local_y_o   (local_y_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: rtl/core/w2v_prerot.sv
// front stage: waypoint minus vehicle position, guard scaling, quarter-turn fold
// depends on w2v_pkg
module w2v_prerot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_i,
  input  w2v_pkg::coord_t    vehicle_x_i,
  input  w2v_pkg::coord_t    vehicle_y_i,
  input  w2v_pkg::heading_t  heading_i,
  input  w2v_pkg::coord_t    point_x_i,
  input  w2v_pkg::coord_t    point_y_i,
  output w2v_pkg::cordic_t   out_o
);
  import w2v_pkg::*;

  logic signed [COORD_WIDTH:0] dx, dy;
  logic signed [XW-1:0]        xe, ye;
  logic signed [XW-1:0]        x_d, y_d;
  logic signed [ANG_W-1:0]     ang, ang_adj;
  logic [HEAD_W-1:0]           neg_head;
  logic signed [ZW-1:0]        z_d;
  logic                        valid_q;
  logic signed [XW-1:0]        x_q, y_q;
  logic signed [ZW-1:0]        z_q;

  always_comb begin
    dx       = (COORD_WIDTH+1)'(point_x_i) - (COORD_WIDTH+1)'(vehicle_x_i);
    dy       = (COORD_WIDTH+1)'(point_y_i) - (COORD_WIDTH+1)'(vehicle_y_i);
    xe       = XW'(dx) <<< GUARD_BITS;
    ye       = XW'(dy) <<< GUARD_BITS;
    neg_head = HEAD_W'(~heading_i + HEAD_W'(1));
    ang      = ANG_W'($signed(neg_head));
    if (ang > QUARTER) begin
      x_d     = -ye;
      y_d     = xe;
      ang_adj = ang - QUARTER;
    end else if (ang < -QUARTER) begin
      x_d     = ye;
      y_d     = -xe;
      ang_adj = ang + QUARTER;
    end else begin
      x_d     = xe;
      y_d     = ye;
      ang_adj = ang;
    end
    z_d = ZW'(ang_adj) <<< ZFRAC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign out_o = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule

FILE: rtl/core/w2v_cordic_cell.sv
// one cordic rotation step with its own register, chained into the rotation row
// depends on w2v_pkg
module w2v_cordic_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [w2v_pkg::SHIFT_W-1:0]     shift_i,
  input  logic signed [w2v_pkg::ZW-1:0]   atan_i,
  input  w2v_pkg::cordic_t                in_i,
  output w2v_pkg::cordic_t                out_o
);
  import w2v_pkg::*;

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 valid_q;

  always_comb begin
    xs = in_i.x >>> shift_i;
    ys = in_i.y >>> shift_i;
    if (!in_i.z[ZW-1]) begin
      x_d = in_i.x - ys;
      y_d = in_i.y + xs;
      z_d = in_i.z - atan_i;
    end else begin
      x_d = in_i.x + ys;
      y_d = in_i.y - xs;
      z_d = in_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign out_o = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule

FILE: rtl/core/w2v_gain.sv
// gain correction with rounding, then saturation to the output range; four stages
// depends on w2v_pkg
module w2v_gain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  w2v_pkg::cordic_t in_i,
  output logic             valid_o,
  output w2v_pkg::coord_t  local_x_o,
  output w2v_pkg::coord_t  local_y_o,
  output logic             saturated_o
);
  import w2v_pkg::*;

  localparam logic [FULL_W-1:0] ROUND_HALF = FULL_W'(1) << (GAIN_SHIFT - 1);
  localparam logic [R_W-1:0]    MAX_MAG    = R_W'(OUT_MAX);
  localparam logic [R_W-1:0]    MIN_MAG    = R_W'(OUT_MAX) + R_W'(1);

  logic [3:0]              valid_q;
  logic [MAGP_W-1:0]       mag_q  [2];
  logic [1:0]              neg1_q, neg2_q, neg3_q;
  logic [PROD_W-1:0]       prod_q [2][NCHUNK];
  logic [FULL_W-1:0]       acc    [2];
  logic [R_W-1:0]          r_q    [2];
  logic [1:0]              clip;
  logic [R_W-1:0]          sval   [2];
  coord_t                  res    [2];
  coord_t                  local_x_q, local_y_q;
  logic                    saturated_q;
  logic signed [XW-1:0]    lane   [2];

  assign lane[0] = in_i.x;
  assign lane[1] = in_i.y;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc[l] = ROUND_HALF;
      for (int c = 0; c < NCHUNK; c++) begin
        acc[l] = acc[l] + (FULL_W'(prod_q[l][c]) << (c * CHUNK_W));
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sval[l] = neg3_q[l] ? (~r_q[l] + R_W'(1)) : r_q[l];
      if (!neg3_q[l]) begin
        clip[l] = r_q[l] > MAX_MAG;
        res[l]  = clip[l] ? OUT_MAX : sval[l][COORD_WIDTH-1:0];
      end else begin
        clip[l] = r_q[l] > MIN_MAG;
        res[l]  = clip[l] ? OUT_MIN : sval[l][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      mag_q[l]  <= MAGP_W'(lane[l][XW-1] ? -lane[l] : lane[l]);
      neg1_q[l] <= lane[l][XW-1];
      for (int c = 0; c < NCHUNK; c++) begin
        prod_q[l][c] <= PROD_W'(mag_q[l][c*CHUNK_W +: CHUNK_W]) * PROD_W'(GAIN_K);
      end
      neg2_q[l] <= neg1_q[l];
      r_q[l]    <= acc[l][FULL_W-1:GAIN_SHIFT];
      neg3_q[l] <= neg2_q[l];
    end
    local_x_q   <= res[0];
    local_y_q   <= res[1];
    saturated_q <= |clip;
  end

  assign valid_o     = valid_q[3];
  assign local_x_o   = local_x_q;
  assign local_y_o   = local_y_q;
  assign saturated_o = saturated_q;

endmodule

FILE: rtl/core/w2v_checker.sv
// port-level checks for the frame transform, bound to the top level
// depends on w2v_pkg and world_to_vehicle_frame_transform
module w2v_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input w2v_pkg::coord_t   vehicle_x_i,
  input w2v_pkg::coord_t   vehicle_y_i,
  input w2v_pkg::coord_t   point_x_i,
  input w2v_pkg::coord_t   point_y_i,
  input logic              valid_o,
  input w2v_pkg::coord_t   local_x_o,
  input w2v_pkg::coord_t   local_y_o,
  input logic              saturated_o
);
  import w2v_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             warm;
  logic             same_pos;

  assign warm     = (cnt_q == CNT_W'(LATENCY));
  assign cnt_d    = warm ? cnt_q : cnt_q + CNT_W'(1);
  assign same_pos = (point_x_i == vehicle_x_i) && (point_y_i == vehicle_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_one_result_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (valid_o == $past(start_i && !busy_o, LATENCY)))
    else $error("result strobe does not match request latency");

  a_sat_clips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |->
      (local_x_o == OUT_MAX || local_x_o == OUT_MIN ||
       local_y_o == OUT_MAX || local_y_o == OUT_MIN))
    else $error("saturated flag without a clipped value");

  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && valid_o && $past(same_pos, LATENCY)) |->
      (local_x_o == '0 && local_y_o == '0 && !saturated_o))
    else $error("zero offset does not give the origin");

endmodule

bind world_to_vehicle_frame_transform w2v_checker u_w2v_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .vehicle_x_i (vehicle_x_i),
  .vehicle_y_i (vehicle_y_i),
  .point_x_i   (point_x_i),
  .point_y_i   (point_y_i),
  .valid_o     (valid_o),
  .local_x_o   (local_x_o),
  .local_y_o   (local_y_o),
  .saturated_o (saturated_o)
);
